// File: hw/rtl/sdspi_pkg.sv
// Package for the SD card SPI command and init engine.
// Holds the transfer structs, command and phase codes, status codes and a frame helper.
// No dependencies.
package sdspi_pkg;

  typedef enum logic [1:0] {
    CMD_ISSUE = 2'd0,
    CMD_INIT  = 2'd1,
    CMD_BYTE  = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_WAIT  = 3'd1,
    PH_FRAME = 3'd2,
    PH_RESP  = 3'd3,
    PH_TRAIL = 3'd4
  } phase_t;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_TIMEOUT     = 3'd1;
  localparam logic [2:0] ST_REMOVED     = 3'd2;
  localparam logic [2:0] ST_CMD8_ILLEGAL = 3'd3;
  localparam logic [2:0] ST_ECHO        = 3'd4;
  localparam logic [2:0] ST_OCR_FAIL    = 3'd5;
  localparam logic [2:0] ST_NOT_HC      = 3'd6;

  localparam logic [2:0] STEP_CMD0  = 3'd0;
  localparam logic [2:0] STEP_CMD8  = 3'd1;
  localparam logic [2:0] STEP_CMD55 = 3'd2;
  localparam logic [2:0] STEP_ACMD41 = 3'd3;
  localparam logic [2:0] STEP_CMD58 = 3'd4;

  localparam logic [5:0] IDX_CMD0   = 6'd0;
  localparam logic [5:0] IDX_CMD8   = 6'd8;
  localparam logic [5:0] IDX_CMD41  = 6'd41;
  localparam logic [5:0] IDX_CMD55  = 6'd55;
  localparam logic [5:0] IDX_CMD58  = 6'd58;

  localparam logic [31:0] ARG_CMD8   = 32'h0000_01AA;
  localparam logic [31:0] ARG_ACMD41 = 32'h4000_0000;

  localparam logic [7:0] BYTE_IDLE  = 8'hFF;
  localparam logic [7:0] R1_IDLE    = 8'h01;
  localparam logic [7:0] ECHO_CHECK = 8'hAA;

  localparam logic [0:0] REG_INIT_TIMEOUT = 1'b0;
  localparam logic [0:0] REG_CMD_TIMEOUT  = 1'b1;

  localparam logic [15:0] INIT_TIMEOUT_RESET = 16'd2000;
  localparam logic [15:0] CMD_TIMEOUT_RESET  = 16'd300;

  typedef struct packed {
    logic [1:0]  command;
    logic [5:0]  sd_index;
    logic [31:0] argument;
    logic        card_number;
    logic [7:0]  miso_byte;
    logic        card_absent;
  } in_item_t;

  typedef struct packed {
    logic [7:0] mosi_byte;
    logic       mosi_valid;
    logic       cs_active;
    logic       cs_card;
    logic       done_res;
    logic [2:0] status;
    logic [7:0] r1_response;
  } out_item_t;

  // Builds the six-byte command frame with its fixed check byte.
  function automatic logic [47:0] build_frame(input logic [5:0] idx, input logic [31:0] arg);
    logic [7:0] chk;
    begin
      if (idx == IDX_CMD0) begin
        chk = 8'h95;
      end else if (idx == IDX_CMD8) begin
        chk = 8'h87;
      end else begin
        chk = 8'hFF;
      end
      build_frame = {2'b01, idx, arg, chk};
    end
  endfunction

endpackage

// File: hw/rtl/sdspi_pipe_reg.sv
// One-entry valid/ready register stage used on the input and result sides.
// Depends on nothing but its width parameter.
module sdspi_pipe_reg #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_valid,
  output logic         s_ready,
  input  logic [W-1:0] s_data,
  output logic         m_valid,
  input  logic         m_ready,
  output logic [W-1:0] m_data
);

  logic         full;
  logic [W-1:0] data;

  assign s_ready = !full || m_ready;
  assign m_valid = full;
  assign m_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (s_ready) begin
      full <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      data <= s_data;
    end
  end

endmodule

// File: hw/rtl/sdspi_engine.sv
// Command and init sequencer: configuration registers, engine state and the
// per-item decision logic. Uses sdspi_pkg.
module sdspi_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [0:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                item_valid,
  output logic                item_ready,
  input  sdspi_pkg::in_item_t item,
  output logic                res_valid,
  input  logic                res_ready,
  output sdspi_pkg::out_item_t res
);
  import sdspi_pkg::*;

  logic [15:0] init_timeout_ms;
  logic [15:0] cmd_timeout_ms;

  phase_t      phase, phase_next;
  logic [2:0]  init_step, init_step_next;
  logic [2:0]  byte_count, byte_count_next;
  logic [47:0] frame_shift, frame_shift_next;
  logic [15:0] wait_elapsed, wait_elapsed_next;
  logic [15:0] loop_elapsed, loop_elapsed_next;
  logic [7:0]  last_response, last_response_next;
  logic        active_card, active_card_next;
  logic        is_init, is_init_next;

  logic        emit;
  logic [7:0]  emit_byte;
  logic        fin;
  logic [2:0]  fin_status;
  logic        fire;

  assign fire       = item_valid && res_ready;
  assign item_ready = res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_timeout_ms <= INIT_TIMEOUT_RESET;
      cmd_timeout_ms  <= CMD_TIMEOUT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_INIT_TIMEOUT) begin
        init_timeout_ms <= cfg_data;
      end else begin
        cmd_timeout_ms <= cfg_data;
      end
    end
  end

  always_comb begin
    logic        cd;
    logic [7:0]  cd_r;
    logic        launch;
    logic [5:0]  l_idx;
    logic [31:0] l_arg;
    logic [2:0]  l_step;
    logic [2:0]  l_fail;
    logic        trail;
    logic [2:0]  bc1;
    logic [2:0]  sel;
    logic [47:0] frame_v;

    phase_next         = phase;
    init_step_next     = init_step;
    byte_count_next    = byte_count;
    frame_shift_next   = frame_shift;
    wait_elapsed_next  = wait_elapsed;
    loop_elapsed_next  = loop_elapsed;
    last_response_next = last_response;
    active_card_next   = active_card;
    is_init_next       = is_init;
    emit       = 1'b0;
    emit_byte  = 8'h00;
    fin        = 1'b0;
    fin_status = ST_OK;
    cd     = 1'b0;
    cd_r   = 8'h00;
    launch = 1'b0;
    l_idx  = 6'd0;
    l_arg  = 32'd0;
    l_step = init_step;
    l_fail = ST_TIMEOUT;
    trail  = 1'b0;
    bc1    = byte_count + 3'd1;
    sel    = 3'd5 - bc1;
    frame_v = frame_shift;

    case (item.command)
      CMD_ISSUE: begin
        if (phase == PH_IDLE) begin
          is_init_next     = 1'b0;
          active_card_next = item.card_number;
          launch = 1'b1;
          l_idx  = item.sd_index;
          l_arg  = item.argument;
        end
      end
      CMD_INIT: begin
        if (phase == PH_IDLE) begin
          active_card_next = item.card_number;
          if (item.card_absent) begin
            is_init_next = 1'b0;
            fin          = 1'b1;
            fin_status   = ST_REMOVED;
          end else begin
            is_init_next      = 1'b1;
            loop_elapsed_next = 16'd0;
            if (init_timeout_ms != 16'd0) begin
              launch = 1'b1;
              l_idx  = IDX_CMD0;
              l_step = STEP_CMD0;
            end else begin
              fin        = 1'b1;
              fin_status = ST_TIMEOUT;
            end
          end
        end
      end
      CMD_BYTE: begin
        case (phase)
          PH_WAIT: begin
            if (item.miso_byte == BYTE_IDLE) begin
              phase_next      = PH_FRAME;
              byte_count_next = 3'd0;
              emit      = 1'b1;
              emit_byte = frame_shift[47:40];
            end else if (wait_elapsed < cmd_timeout_ms) begin
              emit      = 1'b1;
              emit_byte = BYTE_IDLE;
            end else begin
              cd   = 1'b1;
              cd_r = BYTE_IDLE;
            end
          end
          PH_FRAME: begin
            byte_count_next = bc1;
            if (bc1 < 3'd6) begin
              emit      = 1'b1;
              emit_byte = frame_shift[{sel, 3'b000} +: 8];
            end else begin
              wait_elapsed_next = 16'd0;
              if (cmd_timeout_ms != 16'd0) begin
                phase_next = PH_RESP;
                emit       = 1'b1;
                emit_byte  = BYTE_IDLE;
              end else begin
                cd   = 1'b1;
                cd_r = BYTE_IDLE;
              end
            end
          end
          PH_RESP: begin
            if (!item.miso_byte[7]) begin
              cd   = 1'b1;
              cd_r = item.miso_byte;
            end else if (wait_elapsed < cmd_timeout_ms) begin
              emit      = 1'b1;
              emit_byte = BYTE_IDLE;
            end else begin
              cd   = 1'b1;
              cd_r = item.miso_byte;
            end
          end
          PH_TRAIL: begin
            if (init_step == STEP_CMD8 || byte_count == 3'd0) begin
              frame_v = {40'd0, item.miso_byte};
            end
            frame_shift_next = frame_v;
            byte_count_next  = bc1;
            if (bc1 < 3'd4) begin
              emit      = 1'b1;
              emit_byte = BYTE_IDLE;
            end else if (init_step == STEP_CMD8) begin
              if (frame_v[7:0] != ECHO_CHECK) begin
                fin        = 1'b1;
                fin_status = ST_ECHO;
              end else if (item.card_absent) begin
                fin        = 1'b1;
                fin_status = ST_REMOVED;
              end else begin
                loop_elapsed_next = 16'd0;
                if (init_timeout_ms != 16'd0) begin
                  launch = 1'b1;
                  l_idx  = IDX_CMD55;
                  l_step = STEP_CMD55;
                end else begin
                  fin        = 1'b1;
                  fin_status = ST_TIMEOUT;
                end
              end
            end else if (frame_v[7:6] != 2'b11) begin
              fin        = 1'b1;
              fin_status = ST_NOT_HC;
            end else begin
              fin        = 1'b1;
              fin_status = ST_OK;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        if (wait_elapsed != 16'hFFFF) begin
          wait_elapsed_next = wait_elapsed + 16'd1;
        end
        if (loop_elapsed != 16'hFFFF) begin
          loop_elapsed_next = loop_elapsed + 16'd1;
        end
      end
    endcase

    // A finished command either ends the operation or moves the init sequence on.
    if (cd) begin
      last_response_next = cd_r;
      if (!is_init) begin
        fin        = 1'b1;
        fin_status = cd_r[7] ? ST_TIMEOUT : ST_OK;
      end else begin
        case (init_step)
          STEP_CMD0: begin
            if (cd_r == R1_IDLE) begin
              launch = 1'b1;
              l_idx  = IDX_CMD8;
              l_arg  = ARG_CMD8;
              l_step = STEP_CMD8;
              l_fail = ST_CMD8_ILLEGAL;
            end else if (loop_elapsed < init_timeout_ms) begin
              launch = 1'b1;
              l_idx  = IDX_CMD0;
              l_step = STEP_CMD0;
            end else begin
              fin        = 1'b1;
              fin_status = ST_TIMEOUT;
            end
          end
          STEP_CMD8: begin
            if (cd_r[2]) begin
              fin        = 1'b1;
              fin_status = ST_CMD8_ILLEGAL;
            end else begin
              trail = 1'b1;
            end
          end
          STEP_CMD55: begin
            launch = 1'b1;
            l_idx  = IDX_CMD41;
            l_arg  = ARG_ACMD41;
            l_step = STEP_ACMD41;
          end
          STEP_ACMD41: begin
            if (cd_r != 8'h00) begin
              if (loop_elapsed < init_timeout_ms) begin
                launch = 1'b1;
                l_idx  = IDX_CMD55;
                l_step = STEP_CMD55;
              end else begin
                fin        = 1'b1;
                fin_status = ST_TIMEOUT;
              end
            end else if (item.card_absent) begin
              fin        = 1'b1;
              fin_status = ST_REMOVED;
            end else begin
              launch = 1'b1;
              l_idx  = IDX_CMD58;
              l_step = STEP_CMD58;
              l_fail = ST_OCR_FAIL;
            end
          end
          default: begin
            if (cd_r != 8'h00) begin
              fin        = 1'b1;
              fin_status = ST_OCR_FAIL;
            end else begin
              trail = 1'b1;
            end
          end
        endcase
      end
    end

    if (trail) begin
      phase_next       = PH_TRAIL;
      byte_count_next  = 3'd0;
      frame_shift_next = 48'd0;
      emit      = 1'b1;
      emit_byte = BYTE_IDLE;
    end

    // With a zero command timeout the new command fails at once with an idle response and its step's fail status.
    if (launch) begin
      init_step_next    = l_step;
      frame_shift_next  = build_frame(l_idx, l_arg);
      wait_elapsed_next = 16'd0;
      if (cmd_timeout_ms != 16'd0) begin
        phase_next = PH_WAIT;
        emit       = 1'b1;
        emit_byte  = BYTE_IDLE;
      end else begin
        last_response_next = BYTE_IDLE;
        fin        = 1'b1;
        fin_status = l_fail;
      end
    end

    if (fin) begin
      phase_next   = PH_IDLE;
      is_init_next = 1'b0;
    end
  end

  always_comb begin
    res_valid       = fire && (emit || fin);
    res.mosi_byte   = emit ? emit_byte : 8'h00;
    res.mosi_valid  = emit;
    res.cs_active   = emit;
    res.cs_card     = active_card_next;
    res.done_res    = fin;
    res.status      = fin ? fin_status : ST_OK;
    res.r1_response = last_response_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      init_step     <= STEP_CMD0;
      byte_count    <= 3'd0;
      frame_shift   <= 48'd0;
      wait_elapsed  <= 16'd0;
      loop_elapsed  <= 16'd0;
      last_response <= BYTE_IDLE;
      active_card   <= 1'b0;
      is_init       <= 1'b0;
    end else if (fire) begin
      phase         <= phase_next;
      init_step     <= init_step_next;
      byte_count    <= byte_count_next;
      frame_shift   <= frame_shift_next;
      wait_elapsed  <= wait_elapsed_next;
      loop_elapsed  <= loop_elapsed_next;
      last_response <= last_response_next;
      active_card   <= active_card_next;
      is_init       <= is_init_next;
    end
  end

endmodule

// File: hw/rtl/sd_spi_command_and_init_engine_top.sv
// Channel    | Direction | Transfer contents
// in         | input     | in_item_t: command, index, argument, card, received byte, detect
// out        | output    | out_item_t: byte to send, selects, done, status, R1 byte
// cfg        | input     | register index and 16-bit write data
//
// Each item is held in the input register while the engine logic works on it; its result,
// if it has one, then sits in the result register. One item per cycle is sustained while
// the result register is not stalled.
// A stalled result register holds the engine, which then fills the input register.
// Reset (synchronous rst) clears the stages and engine state and loads the timeouts.
// Top level of the SD card SPI command and init engine.
// Uses sdspi_pkg, sdspi_pipe_reg and sdspi_engine.
module sd_spi_command_and_init_engine_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sdspi_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sdspi_pkg::out_item_t out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [0:0]           cfg_index,
  input  logic [15:0]          cfg_data
);
  import sdspi_pkg::*;

  logic      item_valid;
  logic      item_ready;
  in_item_t  item;
  logic      res_valid;
  logic      res_ready;
  out_item_t res;

  assign cfg_ready = 1'b1;

  sdspi_pipe_reg #(
    .W($bits(in_item_t))
  ) u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .s_valid (in_valid),
    .s_ready (in_ready),
    .s_data  (in_item),
    .m_valid (item_valid),
    .m_ready (item_ready),
    .m_data  (item)
  );

  sdspi_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  sdspi_pipe_reg #(
    .W($bits(out_item_t))
  ) u_out_reg (
    .clk     (clk),
    .rst     (rst),
    .s_valid (res_valid),
    .s_ready (res_ready),
    .s_data  (res),
    .m_valid (out_valid),
    .m_ready (out_ready),
    .m_data  (out_item)
  );

endmodule
